// File: sv/assert_macros.svh
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted
`define PEDC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define PEDC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/pedc_pkg.sv
// Widths and constants of the pipe element direction cosine datapath.
`default_nettype none
package pedc_pkg;

	localparam int MATRIX_FRAC_BITS = 30;

	// input and output bus widths
	localparam int COORD_W = 32;
	localparam int IN_W    = 6 * COORD_W;
	localparam int LEN_W   = 35;
	localparam int ENTRY_W = 32;
	localparam int OUT_W   = ((LEN_W + 9 * ENTRY_W + 7) / 8) * 8;

	// datapath widths
	localparam int DIFF_W = COORD_W + 1;
	localparam int MAG_W  = DIFF_W;
	localparam int SQ_W   = 2 * MAG_W - 1;
	localparam int SUM_W  = SQ_W + 1;
	localparam int ROOT_W = SUM_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int SQRT_STEPS = ROOT_W;

	localparam int U_W    = MATRIX_FRAC_BITS + 1;
	localparam int PROD_W = 2 * U_W;
	localparam int QUO_W  = U_W;
	localparam int DIV_STEPS = QUO_W;
	localparam int DEN_W  = REM_W;
	localparam int NUM_W  = MAG_W + MATRIX_FRAC_BITS;

	localparam logic [U_W-1:0] Q_ONE = U_W'(1) << MATRIX_FRAC_BITS;

	// config register widths
	localparam int VTHR_W = 31;
	localparam int MINL_W = 17;
	localparam int CFG_W  = VTHR_W;

	// config register indexes and reset values
	typedef enum logic [0:0] {
		REG_VTHR   = 1'b0,
		REG_MINLEN = 1'b1
	} cfg_reg_t;

	localparam logic [VTHR_W-1:0] VTHR_RESET = VTHR_W'(1074);
	localparam logic [MINL_W-1:0] MINL_RESET = MINL_W'(1);

endpackage
`default_nettype wire

// File: sv/pedc_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module pedc_sqrt import pedc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [SUM_W-1:0]  radicand,
	output logic      [ROOT_W-1:0] root
);

	logic [SUM_W-1:0]  val_s  [SQRT_STEPS];
	logic [REM_W-1:0]  rem_s  [SQRT_STEPS];
	logic [ROOT_W-1:0] root_s [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		logic [SUM_W-1:0]  v_in;
		logic [REM_W-1:0]  r_in;
		logic [ROOT_W-1:0] q_in;
		logic [REM_W+1:0]  r_sh;
		logic [REM_W+1:0]  trial;

		if (k == 0) begin : g_first
			assign v_in = radicand;
			assign r_in = '0;
			assign q_in = '0;
		end else begin : g_next
			assign v_in = val_s[k-1];
			assign r_in = rem_s[k-1];
			assign q_in = root_s[k-1];
		end

		// bring down the next bit pair and try root*4+1
		assign r_sh  = {r_in, v_in[SUM_W-1 -: 2]};
		assign trial = (REM_W+2)'({q_in, 2'b01});

		always_ff @(posedge clk) begin
			if (en) begin
				val_s[k] <= v_in << 2;
				if (r_sh >= trial) begin
					rem_s[k]  <= REM_W'(r_sh - trial);
					root_s[k] <= {q_in[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k]  <= REM_W'(r_sh);
					root_s[k] <= {q_in[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[SQRT_STEPS-1];

endmodule
`default_nettype wire

// File: sv/pedc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module pedc_div import pedc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [QUO_W-1:0] quo
);

	logic [DEN_W-1:0] rem_s [DIV_STEPS];
	logic [DEN_W-1:0] den_s [DIV_STEPS];
	logic [QUO_W-1:0] low_s [DIV_STEPS];
	logic [QUO_W-1:0] quo_s [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [DEN_W-1:0] r_in;
		logic [DEN_W-1:0] d_in;
		logic [QUO_W-1:0] b_in;
		logic [QUO_W-1:0] q_in;
		logic [DEN_W:0]   r_sh;

		// upper numerator bits start as the partial remainder
		if (k == 0) begin : g_first
			assign r_in = DEN_W'(num[NUM_W-1:QUO_W]);
			assign d_in = den;
			assign b_in = num[QUO_W-1:0];
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign d_in = den_s[k-1];
			assign b_in = low_s[k-1];
			assign q_in = quo_s[k-1];
		end

		assign r_sh = {r_in, b_in[QUO_W-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= d_in;
				low_s[k] <= b_in << 1;
				if (r_sh >= {1'b0, d_in}) begin
					rem_s[k] <= DEN_W'(r_sh - {1'b0, d_in});
					quo_s[k] <= {q_in[QUO_W-2:0], 1'b1};
				end else begin
					rem_s[k] <= DEN_W'(r_sh);
					quo_s[k] <= {q_in[QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = quo_s[DIV_STEPS-1];

endmodule
`default_nettype wire

// File: sv/pipe_element_direction_cosines_unit.sv
// Pipe element direction cosine unit: length and 3x3 direction cosine matrix.
// Takes one request per cycle while the output is not stalled; the pipeline
// is built of two square root pipelines (33 stages each), two divider banks
// (31 stages each) and nine stages of add, multiply and select.
// A result that is not taken holds the whole pipeline, and s_tready falls in
// that cycle. A degenerate element (length at or below min_length) returns its
// length with an all-zero matrix and tuser set. Configuration writes must land
// while the pipeline is empty.
`default_nettype none
module pipe_element_direction_cosines_unit import pedc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// start_x, start_y, start_z, end_x, end_y, end_z, from bit 0 up
	input  wire logic [IN_W-1:0]  s_tdata,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// elem_length, r00, r01, r02, r10, r11, r12, r20, r21, r22, zero pad
	output logic      [OUT_W-1:0] m_tdata,
	// degenerate
	output logic                  m_tuser,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	input  wire logic             cfg_we,
	input  wire logic             cfg_addr,
	input  wire logic [CFG_W-1:0] cfg_wdata
);

	localparam int PIPE_LAT = 3 + SQRT_STEPS + 1 + DIV_STEPS + 3 + SQRT_STEPS + 1
		+ DIV_STEPS + 1;

	typedef struct packed {
		logic [2:0]            neg;
		logic [2:0][MAG_W-1:0] mag;
	} seg_a_t;

	typedef struct packed {
		logic [ROOT_W-1:0] len;
		logic              degen;
		logic [2:0]        neg;
	} seg_b_t;

	typedef struct packed {
		logic [ROOT_W-1:0]   len;
		logic                degen;
		logic [2:0]          uneg;
		logic [2:0][U_W-1:0] umag;
	} seg_u_t;

	typedef struct packed {
		seg_u_t            u;
		logic [PROD_W-1:0] pxz;
		logic [PROD_W-1:0] pyz;
	} seg_c_t;

	typedef struct packed {
		seg_u_t         u;
		logic [U_W-1:0] a;
		logic           vert;
	} seg_d_t;

	function automatic logic [ENTRY_W-1:0] signed_entry(input logic neg,
		input logic [U_W-1:0] mag);
		logic [ENTRY_W-1:0] ext;
		ext = ENTRY_W'(mag);
		return neg ? -ext : ext;
	endfunction

	function automatic logic [U_W-1:0] clamp_one(input logic [DEN_W-1:0] v);
		return (v > DEN_W'(Q_ONE)) ? Q_ONE : v[U_W-1:0];
	endfunction

	logic en;
	logic [PIPE_LAT-1:0] vld_q;
	logic [VTHR_W-1:0] vthr_q;
	logic [MINL_W-1:0] minl_q;

	// pipeline moves whenever the output register is free or being taken
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[PIPE_LAT-1];

	// valid bits follow the data down the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], s_tvalid};
		end
	end

	// config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vthr_q <= VTHR_RESET;
			minl_q <= MINL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_VTHR:   vthr_q <= cfg_wdata;
				REG_MINLEN: minl_q <= cfg_wdata[MINL_W-1:0];
				default:    vthr_q <= vthr_q;
			endcase
		end
	end

	// stage 1: coordinate differences
	logic [DIFF_W-1:0] d_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= {s_tdata[COORD_W*(i+3)+COORD_W-1], s_tdata[COORD_W*(i+3) +: COORD_W]}
					- {s_tdata[COORD_W*i+COORD_W-1], s_tdata[COORD_W*i +: COORD_W]};
			end
		end
	end

	// stage 2: magnitudes and squares
	logic [MAG_W-1:0] mag_c [3];
	seg_a_t sa_s2;
	logic [SQ_W-1:0] sq_s2 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = d_s1[i][DIFF_W-1] ? MAG_W'(-d_s1[i]) : d_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sa_s2.neg[i] <= d_s1[i][DIFF_W-1];
				sa_s2.mag[i] <= mag_c[i];
				sq_s2[i]     <= mag_c[i] * mag_c[i];
			end
		end
	end

	// stage 3: sum of squares
	seg_a_t sa_s3;
	logic [SUM_W-1:0] sum_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sa_s3  <= sa_s2;
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		end
	end

	// length root, side data delayed alongside
	logic [ROOT_W-1:0] len_root;
	seg_a_t sa_line_s [SQRT_STEPS];

	pedc_sqrt u_len_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (sum_s3),
		.root     (len_root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sa_line_s[0] <= sa_s3;
			for (int k = 1; k < SQRT_STEPS; k++) begin
				sa_line_s[k] <= sa_line_s[k-1];
			end
		end
	end

	// stage 4: degenerate check and unit vector numerators
	seg_b_t sb_s4;
	logic [NUM_W-1:0] num_s4 [3];
	seg_a_t sa_o;

	assign sa_o = sa_line_s[SQRT_STEPS-1];

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s4.len   <= len_root;
			sb_s4.degen <= len_root <= ROOT_W'(minl_q);
			sb_s4.neg   <= sa_o.neg;
			for (int i = 0; i < 3; i++) begin
				num_s4[i] <= NUM_W'({sa_o.mag[i], {MATRIX_FRAC_BITS{1'b0}}})
					+ NUM_W'(len_root >> 1);
			end
		end
	end

	// unit vector dividers
	logic [QUO_W-1:0] uq [3];
	seg_b_t sb_line_s [DIV_STEPS];

	for (genvar i = 0; i < 3; i++) begin : g_udiv
		pedc_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s4[i]),
			.den (DEN_W'(sb_s4.len)),
			.quo (uq[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_line_s[0] <= sb_s4;
			for (int k = 1; k < DIV_STEPS; k++) begin
				sb_line_s[k] <= sb_line_s[k-1];
			end
		end
	end

	// stage 5: clamp unit vector, drop sign of a zero
	seg_u_t su_s5;
	logic [U_W-1:0] uc [3];
	seg_b_t sb_o;

	assign sb_o = sb_line_s[DIV_STEPS-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			uc[i] = clamp_one(DEN_W'(uq[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			su_s5.len   <= sb_o.len;
			su_s5.degen <= sb_o.degen;
			for (int i = 0; i < 3; i++) begin
				su_s5.umag[i] <= uc[i];
				su_s5.uneg[i] <= sb_o.neg[i] && (uc[i] != '0);
			end
		end
	end

	// stage 6: squares and cross products of the unit vector
	seg_u_t su_s6;
	logic [PROD_W-1:0] sqx_s6, sqy_s6, pxz_s6, pyz_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			su_s6  <= su_s5;
			sqx_s6 <= su_s5.umag[0] * su_s5.umag[0];
			sqy_s6 <= su_s5.umag[1] * su_s5.umag[1];
			pxz_s6 <= su_s5.umag[0] * su_s5.umag[2];
			pyz_s6 <= su_s5.umag[1] * su_s5.umag[2];
		end
	end

	// stage 7: horizontal sum
	seg_c_t sc_s7;
	logic [PROD_W-1:0] hsum_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			sc_s7.u   <= su_s6;
			sc_s7.pxz <= pxz_s6;
			sc_s7.pyz <= pyz_s6;
			hsum_s7   <= sqx_s6 + sqy_s6;
		end
	end

	// horizontal root
	logic [ROOT_W-1:0] a_root;
	seg_c_t sc_line_s [SQRT_STEPS];

	pedc_sqrt u_horiz_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (SUM_W'(hsum_s7)),
		.root     (a_root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sc_line_s[0] <= sc_s7;
			for (int k = 1; k < SQRT_STEPS; k++) begin
				sc_line_s[k] <= sc_line_s[k-1];
			end
		end
	end

	// stage 8: vertical check and row 1/2 numerators
	seg_d_t sd_s8;
	logic [NUM_W-1:0] num2_s8 [4];
	logic [U_W-1:0] a_c;
	seg_c_t sc_o;

	assign sc_o = sc_line_s[SQRT_STEPS-1];
	assign a_c  = clamp_one(DEN_W'(a_root));

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s8.u    <= sc_o.u;
			sd_s8.a    <= a_c;
			sd_s8.vert <= (a_c == '0) || (a_c < vthr_q);
			num2_s8[0] <= NUM_W'({sc_o.u.umag[1], {MATRIX_FRAC_BITS{1'b0}}})
				+ NUM_W'(a_c >> 1);
			num2_s8[1] <= NUM_W'({sc_o.u.umag[0], {MATRIX_FRAC_BITS{1'b0}}})
				+ NUM_W'(a_c >> 1);
			num2_s8[2] <= NUM_W'(sc_o.pxz) + NUM_W'(a_c >> 1);
			num2_s8[3] <= NUM_W'(sc_o.pyz) + NUM_W'(a_c >> 1);
		end
	end

	// row 1/2 dividers
	logic [QUO_W-1:0] mq [4];
	seg_d_t sd_line_s [DIV_STEPS];

	for (genvar i = 0; i < 4; i++) begin : g_mdiv
		pedc_div u_div (
			.clk (clk),
			.en  (en),
			.num (num2_s8[i]),
			.den (DEN_W'(sd_s8.a)),
			.quo (mq[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_line_s[0] <= sd_s8;
			for (int k = 1; k < DIV_STEPS; k++) begin
				sd_line_s[k] <= sd_line_s[k-1];
			end
		end
	end

	// stage 9: select the matrix into the output register
	seg_d_t sd_o;
	logic [ENTRY_W-1:0] r_c [9];
	logic [ENTRY_W-1:0] r_s9 [9];
	logic [ROOT_W-1:0] len_s9;
	logic deg_s9;
	logic [ENTRY_W-1:0] one_e;

	assign sd_o  = sd_line_s[DIV_STEPS-1];
	assign one_e = ENTRY_W'(Q_ONE);

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			r_c[i] = '0;
		end
		if (sd_o.u.degen) begin
			r_c[0] = '0;
		end else if (sd_o.vert) begin
			r_c[2] = sd_o.u.uneg[2] ? -one_e : one_e;
			r_c[4] = one_e;
			r_c[6] = sd_o.u.uneg[2] ? one_e : -one_e;
		end else begin
			r_c[0] = signed_entry(sd_o.u.uneg[0], sd_o.u.umag[0]);
			r_c[1] = signed_entry(sd_o.u.uneg[1], sd_o.u.umag[1]);
			r_c[2] = signed_entry(sd_o.u.uneg[2], sd_o.u.umag[2]);
			r_c[3] = signed_entry(!sd_o.u.uneg[1] && (sd_o.u.umag[1] != '0),
				clamp_one(DEN_W'(mq[0])));
			r_c[4] = signed_entry(sd_o.u.uneg[0], clamp_one(DEN_W'(mq[1])));
			r_c[6] = signed_entry(sd_o.u.uneg[0] == sd_o.u.uneg[2],
				clamp_one(DEN_W'(mq[2])));
			r_c[7] = signed_entry(sd_o.u.uneg[1] == sd_o.u.uneg[2],
				clamp_one(DEN_W'(mq[3])));
			r_c[8] = ENTRY_W'(sd_o.a);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s9 <= sd_o.u.len;
			deg_s9 <= sd_o.u.degen;
			for (int i = 0; i < 9; i++) begin
				r_s9[i] <= r_c[i];
			end
		end
	end

	// pack the result request
	always_comb begin
		m_tdata = '0;
		m_tdata[LEN_W-1:0] = LEN_W'(len_s9);
		for (int i = 0; i < 9; i++) begin
			m_tdata[LEN_W + ENTRY_W*i +: ENTRY_W] = r_s9[i];
		end
	end

	assign m_tuser = deg_s9;

endmodule
`default_nettype wire

// File: sv/pedc_checker.sv
// Port-level checks for the direction cosine unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module pedc_port_props import pedc_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic [IN_W-1:0]  s_tdata,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic [OUT_W-1:0] m_tdata,
	input wire logic             m_tuser,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic             cfg_we,
	input wire logic             cfg_addr,
	input wire logic [CFG_W-1:0] cfg_wdata
);

	// a stalled result holds its data
	`PEDC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "held")

	// a stalled output holds back new requests
	`PEDC_ASSERT(a_stall_in, m_tvalid && !m_tready |-> !s_tready, "request taken in stall")

	// degenerate elements carry a zero matrix
	`PEDC_ASSERT(a_degen_zero, m_tvalid && m_tuser |-> m_tdata[OUT_W-6:LEN_W] == '0, "degen")

	// r22 is the horizontal part, never negative and at most one
	`PEDC_ASSERT(a_r22_range, m_tvalid |-> m_tdata[LEN_W+8*ENTRY_W +: ENTRY_W] <= ENTRY_W'(Q_ONE), "r22")

	// no result shown while in reset
	`PEDC_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !m_tvalid, "output valid during reset")

endmodule

bind pipe_element_direction_cosines_unit pedc_port_props u_pedc_port_props (.*);
`default_nettype wire
